FILE: rtl/s12cr_pkg.sv
// Package: shared types, constants and helpers of the SDI-12 command recognizer.
`default_nettype none
package s12cr_pkg;

  localparam int CmdDepth   = 4;
  localparam int LenW       = $clog2(CmdDepth + 1);
  localparam int IdxW       = $clog2(CmdDepth);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int TickW      = 16;
  localparam int AddrW      = 7;
  localparam int KindW      = 3;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgDefaultAddress = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgStreamInterval = 1'd1;

  localparam logic [AddrW-1:0]  DefaultAddressRst = 7'd48;
  localparam logic [TickW-1:0]  StreamIntervalRst = 16'd1000;
  localparam logic [TickW-1:0]  TickMax           = 16'hFFFF;

  localparam logic [7:0] ByteLo = 8'd32;
  localparam logic [7:0] ByteHi = 8'd126;

  localparam logic [AddrW-1:0] ChSpace = 7'h20;
  localparam logic [AddrW-1:0] ChBang  = 7'h21;
  localparam logic [AddrW-1:0] ChQuery = 7'h3F;
  localparam logic [AddrW-1:0] ChA     = 7'h41;
  localparam logic [AddrW-1:0] ChM     = 7'h4D;
  localparam logic [AddrW-1:0] ChD     = 7'h44;
  localparam logic [AddrW-1:0] ChR     = 7'h52;
  localparam logic [AddrW-1:0] Ch0     = 7'h30;
  localparam logic [AddrW-1:0] Ch1     = 7'h31;
  localparam logic [AddrW-1:0] Ch2     = 7'h32;

  localparam logic [KindW-1:0] KindAddr    = 3'd0;
  localparam logic [KindW-1:0] KindMeasure = 3'd1;
  localparam logic [KindW-1:0] KindData1   = 3'd2;
  localparam logic [KindW-1:0] KindData2   = 3'd3;
  localparam logic [KindW-1:0] KindAll     = 3'd4;
  localparam logic [KindW-1:0] KindStream  = 3'd5;

  typedef enum logic [1:0] {
    ITEM_TICK,
    ITEM_TERM,
    ITEM_CHAR
  } item_kind_e;

  typedef struct packed {
    item_kind_e       kind;
    logic [AddrW-1:0] ch;
  } item_t;

  typedef struct packed {
    logic             addr_wr;
    logic [AddrW-1:0] addr;
    logic [TickW-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [QCntW-1:0] count;
  } q_stat_t;

  function automatic logic is_alnum(input logic [AddrW-1:0] c);
    is_alnum = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
               (c >= 7'h61 && c <= 7'h7A);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/s12cr_if.sv
// Interfaces: input, result and configuration channels.
`default_nettype none
interface s12cr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  modport source (output valid, req_type, rx_byte, input ready);
  modport sink (input valid, req_type, rx_byte, output ready);
endinterface

interface s12cr_out_if;
  logic                           valid;
  logic                           ready;
  logic [s12cr_pkg::KindW-1:0]    resp_kind;
  logic [s12cr_pkg::AddrW-1:0]    resp_addr;
  modport source (output valid, resp_kind, resp_addr, input ready);
  modport sink (input valid, resp_kind, resp_addr, output ready);
endinterface

interface s12cr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [s12cr_pkg::CfgIdxW-1:0]  index;
  logic [s12cr_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/s12cr_front.sv
// Front end: filter received bytes and classify each transfer into a queue item.
`default_nettype none
module s12cr_front (
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  input  logic [7:0]           in_rx_byte_i,
  input  logic                 q_full_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output s12cr_pkg::item_t     item_o
);

  logic printable;

  assign printable  = (in_rx_byte_i >= s12cr_pkg::ByteLo) &&
                      (in_rx_byte_i <= s12cr_pkg::ByteHi);
  assign in_ready_o = !q_full_i;

  always_comb begin
    item_o.ch = in_rx_byte_i[s12cr_pkg::AddrW-1:0];
    if (in_req_type_i) begin
      item_o.kind = s12cr_pkg::ITEM_TICK;
    end else if (item_o.ch == s12cr_pkg::ChBang) begin
      item_o.kind = s12cr_pkg::ITEM_TERM;
    end else begin
      item_o.kind = s12cr_pkg::ITEM_CHAR;
    end
  end

  // drop unprintable bytes here
  assign push_o = in_valid_i && !q_full_i && (in_req_type_i || printable);

endmodule
`default_nettype wire

FILE: rtl/s12cr_queue.sv
// Queue: short item buffer between the front end and the command engine.
`default_nettype none
module s12cr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  s12cr_pkg::item_t     item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output s12cr_pkg::item_t     head_o,
  output logic [s12cr_pkg::QCntW-1:0] count_o
);

  s12cr_pkg::item_t mem_q [s12cr_pkg::QueueDepth];
  logic [s12cr_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [s12cr_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [s12cr_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == s12cr_pkg::QCntW'(s12cr_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/s12cr_back.sv
// Command engine: gather characters, decode commands, run the stream timer.
`default_nettype none
module s12cr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s12cr_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  input  s12cr_pkg::item_t     q_head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [s12cr_pkg::KindW-1:0] out_kind_o,
  output logic [s12cr_pkg::AddrW-1:0] out_addr_o
);

  logic [s12cr_pkg::AddrW-1:0] cmd_q [s12cr_pkg::CmdDepth];
  logic [s12cr_pkg::AddrW-1:0] own_q, own_d;
  logic [s12cr_pkg::LenW-1:0]  stored_q, stored_d;
  logic [s12cr_pkg::LenW-1:0]  content_q, content_d;
  logic                        too_long_q, too_long_d;
  logic                        stream_q, stream_d;
  logic [s12cr_pkg::TickW-1:0] ticks_q, ticks_d;
  logic [s12cr_pkg::TickW-1:0] ticks_inc;
  logic                        ovalid_q, ovalid_d;
  logic [s12cr_pkg::KindW-1:0] okind_q, okind_d;
  logic [s12cr_pkg::AddrW-1:0] oaddr_q, oaddr_d;
  logic                        emit;
  logic                        store_wr;
  logic                        has_room;
  logic                        own_match;

  assign pop_o       = q_valid_i && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_addr_o  = oaddr_q;
  assign has_room    = (stored_q < s12cr_pkg::LenW'(s12cr_pkg::CmdDepth));
  assign own_match   = (cmd_q[0] == own_q);
  assign ticks_inc   = (ticks_q == s12cr_pkg::TickMax) ? ticks_q : ticks_q + 1'b1;

  always_comb begin
    own_d      = own_q;
    stored_d   = stored_q;
    content_d  = content_q;
    too_long_d = too_long_q;
    stream_d   = stream_q;
    ticks_d    = ticks_q;
    okind_d    = okind_q;
    oaddr_d    = oaddr_q;
    emit       = 1'b0;
    store_wr   = 1'b0;
    if (pop_o) begin
      case (q_head_i.kind)
        s12cr_pkg::ITEM_TICK: begin
          if (stream_q) begin
            if (ticks_inc >= cfg_i.interval) begin
              ticks_d = '0;
              emit    = 1'b1;
              okind_d = s12cr_pkg::KindStream;
              oaddr_d = own_q;
            end else begin
              ticks_d = ticks_inc;
            end
          end
        end
        s12cr_pkg::ITEM_TERM: begin
          stream_d   = 1'b0;
          stored_d   = '0;
          content_d  = '0;
          too_long_d = 1'b0;
          oaddr_d    = own_q;
          if (!too_long_q && content_q != '0) begin
            if (content_q == s12cr_pkg::LenW'(1) && cmd_q[0] == s12cr_pkg::ChQuery) begin
              emit    = 1'b1;
              okind_d = s12cr_pkg::KindAddr;
            end else if (own_match) begin
              if (content_q == s12cr_pkg::LenW'(3) && cmd_q[1] == s12cr_pkg::ChA) begin
                if (s12cr_pkg::is_alnum(cmd_q[2])) begin
                  emit    = 1'b1;
                  okind_d = s12cr_pkg::KindAddr;
                  own_d   = cmd_q[2];
                  oaddr_d = cmd_q[2];
                end
              end else if (content_q == s12cr_pkg::LenW'(2) &&
                           cmd_q[1] == s12cr_pkg::ChM) begin
                emit    = 1'b1;
                okind_d = s12cr_pkg::KindMeasure;
              end else if (content_q == s12cr_pkg::LenW'(3) && cmd_q[1] == s12cr_pkg::ChD &&
                           cmd_q[2] == s12cr_pkg::Ch1) begin
                emit    = 1'b1;
                okind_d = s12cr_pkg::KindData1;
              end else if (content_q == s12cr_pkg::LenW'(3) && cmd_q[1] == s12cr_pkg::ChD &&
                           cmd_q[2] == s12cr_pkg::Ch2) begin
                emit    = 1'b1;
                okind_d = s12cr_pkg::KindData2;
              end else if (content_q == s12cr_pkg::LenW'(3) && cmd_q[1] == s12cr_pkg::ChR &&
                           cmd_q[2] == s12cr_pkg::Ch0) begin
                emit     = 1'b1;
                okind_d  = s12cr_pkg::KindAll;
                stream_d = 1'b1;
                ticks_d  = '0;
              end
            end
          end
        end
        s12cr_pkg::ITEM_CHAR: begin
          if (!(q_head_i.ch == s12cr_pkg::ChSpace && stored_q == '0)) begin
            if (has_room) begin
              store_wr = 1'b1;
              stored_d = stored_q + 1'b1;
              if (q_head_i.ch != s12cr_pkg::ChSpace) begin
                content_d = stored_q + 1'b1;
              end
            end else if (q_head_i.ch != s12cr_pkg::ChSpace) begin
              too_long_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cfg_i.addr_wr) begin
      own_d = cfg_i.addr;
    end
    if (pop_o) begin
      ovalid_d = emit;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q      <= s12cr_pkg::DefaultAddressRst;
      stored_q   <= '0;
      content_q  <= '0;
      too_long_q <= 1'b0;
      stream_q   <= 1'b0;
      ticks_q    <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      own_q      <= own_d;
      stored_q   <= stored_d;
      content_q  <= content_d;
      too_long_q <= too_long_d;
      stream_q   <= stream_d;
      ticks_q    <= ticks_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oaddr_q <= oaddr_d;
    if (store_wr) begin
      cmd_q[stored_q[s12cr_pkg::IdxW-1:0]] <= q_head_i.ch;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sdi12_command_recognizer.sv
// Top level: SDI-12 sensor command recognizer.
// Takes received bytes (req_type 0) and millisecond ticks (req_type 1) and
// returns at most one response code with its address per item. One item is
// accepted every clock cycle while the queue is not full; a result is
// registered on its way out (front end into a two-entry queue, then the
// command engine into the output register), and the queue absorbs short
// stalls of the result side. Configuration index 0 sets the default address
// and reloads the current address; index 1 sets the stream interval in
// ticks. Write configuration only while no item is in flight.
`default_nettype none
module sdi12_command_recognizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  s12cr_in_if.sink       in_i,
  s12cr_out_if.source    out_o,
  s12cr_cfg_if.sink      cfg_i
);

  logic                        q_full;
  logic                        q_valid;
  logic                        push;
  logic                        pop;
  logic [s12cr_pkg::QCntW-1:0] q_count;
  s12cr_pkg::item_t            item;
  s12cr_pkg::item_t            head;
  s12cr_pkg::cfg_t             cfg;
  s12cr_pkg::q_stat_t          q_stat;
  logic [s12cr_pkg::AddrW-1:0] dflt_addr_q;
  logic [s12cr_pkg::TickW-1:0] interval_q;
  logic                        cfg_wr;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr       = cfg_i.valid;
  assign cfg.addr_wr  = cfg_wr && (cfg_i.index == s12cr_pkg::CfgDefaultAddress);
  assign cfg.addr     = cfg_i.data[s12cr_pkg::AddrW-1:0];
  assign cfg.interval = interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_addr_q <= s12cr_pkg::DefaultAddressRst;
      interval_q  <= s12cr_pkg::StreamIntervalRst;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        s12cr_pkg::CfgDefaultAddress: dflt_addr_q <= cfg_i.data[s12cr_pkg::AddrW-1:0];
        s12cr_pkg::CfgStreamInterval: interval_q  <= cfg_i.data[s12cr_pkg::TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  s12cr_front u_front (
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.req_type),
    .in_rx_byte_i  (in_i.rx_byte),
    .q_full_i      (q_full),
    .in_ready_o    (in_i.ready),
    .push_o        (push),
    .item_o        (item)
  );

  s12cr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head),
    .count_o (q_count)
  );

  s12cr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.resp_kind),
    .out_addr_o  (out_o.resp_addr)
  );

  assign q_stat.push  = push;
  assign q_stat.pop   = pop;
  assign q_stat.count = q_count;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= s12cr_pkg::QCntW'(s12cr_pkg::QueueDepth))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.pop |-> q_stat.count != '0)
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.push && !q_stat.pop) |=> q_stat.count == $past(q_stat.count) + 1'b1)
    else $error("queue count missed a push");

  a_dflt_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.addr_wr |=> dflt_addr_q == $past(cfg.addr))
    else $error("default address not held");
`endif

endmodule
`default_nettype wire
